### rtl/brb_pkg.sv
// ---------------------------------------------------------------------------
// brb_pkg
// Shared constants, codes and types of the byte ring buffer.
// ---------------------------------------------------------------------------
package brb_pkg;

  localparam int BRB_DEPTH      = 1024;
  localparam int BRB_MAX_BYTES  = 8;
  localparam int BRB_RESET_SIZE = 1024;
  localparam int BRB_MAX_SIZE   = 2047;
  localparam int BRB_MIN_SIZE   = 2;

  localparam int KINDW = 3;
  localparam int CNTW  = 10;
  localparam int SZW   = 11;
  localparam int DATAW = 64;
  localparam int BYTEW = 8;
  localparam int LANES = 8;
  localparam int LBW   = 3;
  localparam int NW    = 4;
  localparam int STW   = 2;
  localparam int OUTW  = 10;

  localparam int IN_BITS   = CNTW + DATAW;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STW + DATAW + 6 * OUTW;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [KINDW-1:0] KIND_ENQ  = 3'd0;
  localparam logic [KINDW-1:0] KIND_DEQ  = 3'd1;
  localparam logic [KINDW-1:0] KIND_PEEK = 3'd2;
  localparam logic [KINDW-1:0] KIND_SKIP = 3'd3;
  localparam logic [KINDW-1:0] KIND_ADV  = 3'd4;
  localparam logic [KINDW-1:0] KIND_CLR  = 3'd5;

  localparam logic [STW-1:0] ST_OK      = 2'd0;
  localparam logic [STW-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STW-1:0] ST_NODATA  = 2'd2;
  localparam logic [STW-1:0] ST_BADCNT  = 2'd3;

  typedef struct packed {
    logic           wr;
    logic           rd;
    logic [SZW-1:0] base;
    logic [NW-1:0]  n;
  } brb_op_t;

  typedef struct packed {
    logic [SZW-1:0] size;
    logic [SZW-1:0] used;
    logic [SZW-1:0] free;
  } brb_state_t;

  typedef struct packed {
    logic [OUTW-1:0] used;
    logic [OUTW-1:0] free;
    logic [OUTW-1:0] contig_read;
    logic [OUTW-1:0] contig_write;
    logic [OUTW-1:0] read_position;
    logic [OUTW-1:0] write_position;
  } brb_cnt_t;

  function automatic int brb_slots(int depth);
    return (depth < BRB_MAX_SIZE) ? depth : BRB_MAX_SIZE;
  endfunction

endpackage

### rtl/brb_bank.sv
// ---------------------------------------------------------------------------
// brb_bank
// One byte-wide bank of the store, single port, registered read.
// ---------------------------------------------------------------------------
module brb_bank
  import brb_pkg::*;
#(
  parameter int ROWS = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(ROWS)-1:0]  addr,
  input  logic [BYTEW-1:0]         wdata,
  output logic [BYTEW-1:0]         rdata
);

  logic [BYTEW-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/brb_store.sv
// ---------------------------------------------------------------------------
// brb_store
// Byte store: slots 0..7 in registers, higher slots striped over eight banks.
// Maps the eight lanes of a request onto slots and assembles read data.
// ---------------------------------------------------------------------------
module brb_store
  import brb_pkg::*;
#(
  parameter int DEPTH = BRB_DEPTH
) (
  input  logic             clk,
  input  logic             go,
  input  brb_op_t          op,
  input  logic [SZW-1:0]   size,
  input  logic [DATAW-1:0] data_in,
  output logic [DATAW-1:0] data_out
);

  localparam int MAXS = brb_slots(DEPTH);
  localparam int PW   = $clog2(MAXS);

  logic [SZW:0]       lane_sum [LANES];
  logic [SZW-1:0]     slot     [LANES];
  logic [LANES-1:0]   act;
  logic [LANES-1:0]   slot_lo;
  logic [BYTEW-1:0]   lo       [LANES];
  logic [BYTEW-1:0]   hi_q     [LANES];
  logic [LANES-1:0]   q_rd;
  logic [LANES-1:0]   q_lo;
  logic [LBW-1:0]     q_bank   [LANES];

  // lane i addresses slot base+1+i, wrapped once at size
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_sum[i] = (SZW+1)'(op.base) + (SZW+1)'(i + 1);
      slot[i]     = (lane_sum[i] >= (SZW+1)'(size)) ?
                    SZW'(lane_sum[i] - (SZW+1)'(size)) : SZW'(lane_sum[i]);
      act[i]      = NW'(i) < op.n;
      slot_lo[i]  = slot[i] < SZW'(LANES);
    end
  end

  always_ff @(posedge clk) begin
    if (go && op.wr) begin
      for (int i = 0; i < LANES; i++) begin
        if (act[i] && slot_lo[i]) begin
          lo[slot[i][LBW-1:0]] <= data_in[BYTEW*i +: BYTEW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < LANES; i++) begin
        q_rd[i]   <= op.rd && act[i];
        q_lo[i]   <= slot_lo[i];
        q_bank[i] <= slot[i][LBW-1:0];
      end
    end
  end

  generate
    if (MAXS > LANES) begin : g_hi
      localparam int ROWS = (MAXS - 1) / LANES + 1;
      localparam int RW   = PW - LBW;
      for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic             hit;
        logic [RW-1:0]    row;
        logic [BYTEW-1:0] wbyte;

        // at most one lane lands on a given bank
        always_comb begin
          hit   = 1'b0;
          row   = '0;
          wbyte = '0;
          for (int i = 0; i < LANES; i++) begin
            if (act[i] && !slot_lo[i] && slot[i][LBW-1:0] == LBW'(b)) begin
              hit   = 1'b1;
              row   = row | slot[i][PW-1:LBW];
              wbyte = wbyte | data_in[BYTEW*i +: BYTEW];
            end
          end
        end

        brb_bank #(
          .ROWS (ROWS)
        ) u_bank (
          .clk   (clk),
          .we    (go && op.wr && hit),
          .re    (go && op.rd),
          .addr  (row),
          .wdata (wbyte),
          .rdata (hi_q[b])
        );
      end
    end else begin : g_no_hi
      always_comb begin
        for (int b = 0; b < LANES; b++) begin
          hi_q[b] = '0;
        end
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (!q_rd[i]) begin
        data_out[BYTEW*i +: BYTEW] = '0;
      end else if (q_lo[i]) begin
        data_out[BYTEW*i +: BYTEW] = lo[q_bank[i]];
      end else begin
        data_out[BYTEW*i +: BYTEW] = hi_q[q_bank[i]];
      end
    end
  end

endmodule

### rtl/brb_ctrl.sv
// ---------------------------------------------------------------------------
// brb_ctrl
// Pointer state, request checks and the counts reported with each result.
// ---------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
#(
  parameter int DEPTH     = BRB_DEPTH,
  parameter int MAX_BYTES = BRB_MAX_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [KINDW-1:0] kind,
  input  logic [CNTW-1:0]  count,
  input  logic             cfg_we,
  input  logic [SZW-1:0]   cfg_data,
  output brb_op_t          op,
  output logic [STW-1:0]   status_next,
  output brb_state_t       st,
  output brb_cnt_t         cnt
);

  localparam int MAXS = brb_slots(DEPTH);
  localparam int PW   = $clog2(MAXS);
  localparam int RSTS = (MAXS < BRB_RESET_SIZE) ? MAXS : BRB_RESET_SIZE;

  logic [PW-1:0]  rp, wp, rp_next, wp_next, rp_adv, wp_adv;
  logic [SZW-1:0] size, used, free, used_next, free_next;
  logic [SZW-1:0] cnt_x, cfg_size, room_r, room_w;
  logic [SZW:0]   rp_sum, wp_sum;
  logic           big, short_free, short_data;

  assign cnt_x      = SZW'(count);
  assign big        = count > CNTW'(MAX_BYTES);
  assign short_free = cnt_x > free;
  assign short_data = cnt_x > used;

  assign rp_sum = (SZW+1)'(rp) + (SZW+1)'(cnt_x);
  assign wp_sum = (SZW+1)'(wp) + (SZW+1)'(cnt_x);
  assign rp_adv = (rp_sum >= (SZW+1)'(size)) ? PW'(rp_sum - (SZW+1)'(size)) : PW'(rp_sum);
  assign wp_adv = (wp_sum >= (SZW+1)'(size)) ? PW'(wp_sum - (SZW+1)'(size)) : PW'(wp_sum);

  assign cfg_size = (cfg_data < SZW'(BRB_MIN_SIZE)) ? SZW'(BRB_MIN_SIZE) :
                    (cfg_data > SZW'(MAXS))         ? SZW'(MAXS) : cfg_data;

  always_comb begin
    status_next = ST_OK;
    op.wr       = 1'b0;
    op.rd       = 1'b0;
    rp_next     = rp;
    wp_next     = wp;
    used_next   = used;
    free_next   = free;
    case (kind)
      KIND_ENQ, KIND_ADV: begin
        if (kind == KIND_ENQ && big) begin
          status_next = ST_BADCNT;
        end else if (short_free) begin
          status_next = ST_NOSPACE;
        end else begin
          op.wr     = (kind == KIND_ENQ);
          wp_next   = wp_adv;
          used_next = used + cnt_x;
          free_next = free - cnt_x;
        end
      end
      KIND_DEQ, KIND_PEEK, KIND_SKIP: begin
        if (kind != KIND_SKIP && big) begin
          status_next = ST_BADCNT;
        end else if (short_data) begin
          status_next = ST_NODATA;
        end else begin
          op.rd = (kind != KIND_SKIP);
          if (kind != KIND_PEEK) begin
            rp_next   = rp_adv;
            used_next = used - cnt_x;
            free_next = free + cnt_x;
          end
        end
      end
      KIND_CLR: begin
        rp_next   = '0;
        wp_next   = '0;
        used_next = '0;
        free_next = size - SZW'(1);
      end
      default: begin
        status_next = ST_BADCNT;
      end
    endcase
    op.base = op.wr ? SZW'(wp) : SZW'(rp);
    op.n    = count[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SZW'(RSTS);
      rp   <= '0;
      wp   <= '0;
      used <= '0;
      free <= SZW'(RSTS - 1);
    end else if (cfg_we) begin
      size <= cfg_size;
      rp   <= '0;
      wp   <= '0;
      used <= '0;
      free <= cfg_size - SZW'(1);
    end else if (go) begin
      rp   <= rp_next;
      wp   <= wp_next;
      used <= used_next;
      free <= free_next;
    end
  end

  // room up to the end of the store from the slot after each pointer
  assign room_r = (SZW'(rp) == size - SZW'(1)) ? size : size - SZW'(1) - SZW'(rp);
  assign room_w = (SZW'(wp) == size - SZW'(1)) ? size : size - SZW'(1) - SZW'(wp);

  assign st.size = size;
  assign st.used = used;
  assign st.free = free;

  assign cnt.used           = OUTW'(used);
  assign cnt.free           = OUTW'(free);
  assign cnt.contig_read    = OUTW'((used < room_r) ? used : room_r);
  assign cnt.contig_write   = OUTW'((free < room_w) ? free : room_w);
  assign cnt.read_position  = OUTW'(rp);
  assign cnt.write_position = OUTW'(wp);

endmodule

### rtl/byte_ring_buffer_top.sv
// ---------------------------------------------------------------------------
// byte_ring_buffer_top
// Byte ring buffer, one slot kept empty; one request per cycle unless stalled.
// ---------------------------------------------------------------------------
// Takes one request per cycle while results are taken and returns one result
// per request: an input register, then pointer update, store access and the
// result register in one pass. Slots 0..7 sit in registers and higher slots
// are striped over eight single-port byte banks by slot modulo 8, so an access
// of up to eight bytes, wrapped at any buffer size, touches each bank at most
// once; higher slots are read from the banks' read registers. The store is not
// cleared after reset; reading a never-written slot returns unknown data.
// Write cfg_data only while no request is in flight; it resets both pointers.
module byte_ring_buffer_top
  import brb_pkg::*;
#(
  parameter int DEPTH     = BRB_DEPTH,
  parameter int MAX_BYTES = BRB_MAX_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SZW-1:0]       cfg_data,        // buffer_size
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,    // count, data_in
  input  logic [KINDW-1:0]     s_axis_tuser,    // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata     // status, data_out, used_count,
                                                // free_count, contig_read,
                                                // contig_write, read_position,
                                                // write_position
);

  localparam int M_PAD = M_TDATA_W - OUT_BITS;

  logic             in_valid, out_valid, go, s_accept, out_free;
  logic [KINDW-1:0] in_kind;
  logic [CNTW-1:0]  in_count;
  logic [DATAW-1:0] in_data, data_out;
  logic [STW-1:0]   out_status, status_next;
  brb_op_t          op;
  brb_state_t       st;
  brb_cnt_t         cnt;

  assign out_free      = !out_valid || m_axis_tready;
  assign go            = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= s_accept || (in_valid && !go);
      out_valid <= go || (out_valid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_kind  <= s_axis_tuser;
      in_count <= s_axis_tdata[CNTW-1:0];
      in_data  <= s_axis_tdata[CNTW +: DATAW];
    end
    if (go) begin
      out_status <= status_next;
    end
  end

  brb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BYTES (MAX_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .kind        (in_kind),
    .count       (in_count),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .op          (op),
    .status_next (status_next),
    .st          (st),
    .cnt         (cnt)
  );

  brb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .go       (go),
    .op       (op),
    .size     (st.size),
    .data_in  (in_data),
    .data_out (data_out)
  );

  assign m_axis_tdata = {M_PAD'(1'b0), cnt.write_position, cnt.read_position,
                         cnt.contig_write, cnt.contig_read, cnt.free, cnt.used,
                         data_out, out_status};

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    go |=> m_axis_tvalid)
    else $error("request processed without a result");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    ((SZW+1)'(st.used) + (SZW+1)'(st.free) + (SZW+1)'(1)) == (SZW+1)'(st.size))
    else $error("used plus free does not match buffer size");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    go && !cfg_valid && status_next != ST_OK |=>
      $stable(cnt.read_position) && $stable(cnt.write_position) && $stable(st.used))
    else $error("refused request moved a pointer");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_ring_buffer_top. A short table of directed
// requests covers the empty and full buffer, every operation, oversized and
// zero counts, reserved kinds and pointer wrap. It is followed by phases of
// random requests over a range of buffer sizes, with random idling on both
// streams, long result stalls and drained pauses. Every result is compared
// field by field, typed rows to fixed values, the rest to a behavioral model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import brb_pkg::*;

  localparam logic [KINDW-1:0] KIND_RSVD_LO = 3'd6;
  localparam logic [KINDW-1:0] KIND_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [OUTW-1:0]  write_position;
    logic [OUTW-1:0]  read_position;
    logic [OUTW-1:0]  contig_write;
    logic [OUTW-1:0]  contig_read;
    logic [OUTW-1:0]  free_count;
    logic [OUTW-1:0]  used_count;
    logic [DATAW-1:0] data_out;
    logic [STW-1:0]   status;
  } ring_result_t;

  typedef struct {
    logic [KINDW-1:0] kind;
    logic [CNTW-1:0]  count;
    logic [DATAW-1:0] data;
    bit               typed;
    ring_result_t     res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SZW-1:0]       cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // count, data_in
  logic [KINDW-1:0]     s_axis_tuser = '0;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // status, data_out, used_count,
                                             // free_count, contig_read,
                                             // contig_write, read_position,
                                             // write_position

  // ring model state
  logic [7:0]   ring_mem [BRB_DEPTH];
  bit           slot_written [BRB_DEPTH];
  int           ring_size = BRB_RESET_SIZE;
  int           rd_ptr = 0;
  int           wr_ptr = 0;

  ring_result_t pending_results [$];
  dir_row_t     dir_tab [$];
  int           mismatch_count = 0;
  bit           idle_on = 1'b1;
  int           rx_hold = 0;

  byte_ring_buffer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("byte_ring_buffer_top test failed");
    $finish;
  end

  function automatic int pick_gap();
    return idle_on ? $urandom_range(0, 7) : 0;
  endfunction

  function automatic int ring_used();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring_size - (rd_ptr - wr_ptr);
  endfunction

  // applies one request to the ring model and returns the result it gives
  function automatic ring_result_t ring_access(input logic [KINDW-1:0] kind,
                                               input int cnt,
                                               input logic [DATAW-1:0] din);
    ring_result_t r;
    int used;
    int freec;
    int p;
    r = '0;
    used = ring_used();
    freec = ring_size - 1 - used;
    if (kind <= KIND_PEEK && cnt > BRB_MAX_BYTES) begin
      r.status = ST_BADCNT;
    end else if (kind == KIND_ENQ || kind == KIND_ADV) begin
      if (cnt > freec) begin
        r.status = ST_NOSPACE;
      end else if (kind == KIND_ENQ) begin
        for (int i = 0; i < cnt; i++) begin
          wr_ptr = (wr_ptr + 1) % ring_size;
          ring_mem[wr_ptr] = din[8*i +: 8];
          slot_written[wr_ptr] = 1'b1;
        end
      end else begin
        wr_ptr = (wr_ptr + cnt) % ring_size;
      end
    end else if (kind >= KIND_DEQ && kind <= KIND_SKIP) begin
      if (cnt > used) begin
        r.status = ST_NODATA;
      end else begin
        if (kind != KIND_SKIP) begin
          p = rd_ptr;
          for (int i = 0; i < cnt; i++) begin
            p = (p + 1) % ring_size;
            r.data_out[8*i +: 8] = ring_mem[p];
          end
        end
        if (kind != KIND_PEEK) rd_ptr = (rd_ptr + cnt) % ring_size;
      end
    end else if (kind == KIND_CLR) begin
      rd_ptr = 0;
      wr_ptr = 0;
    end else begin
      r.status = ST_BADCNT;
    end
    used = ring_used();
    freec = ring_size - 1 - used;
    r.used_count = OUTW'(used);
    r.free_count = OUTW'(freec);
    p = (rd_ptr + 1) % ring_size;
    r.contig_read = OUTW'((used < ring_size - p) ? used : ring_size - p);
    p = (wr_ptr + 1) % ring_size;
    r.contig_write = OUTW'((freec < ring_size - p) ? freec : ring_size - p);
    r.read_position = OUTW'(rd_ptr);
    r.write_position = OUTW'(wr_ptr);
    return r;
  endfunction

  function automatic dir_row_t make_row(input logic [KINDW-1:0] kind,
                                        input logic [CNTW-1:0] cnt,
                                        input logic [DATAW-1:0] din,
                                        input bit typed = 1'b0,
                                        input logic [STW-1:0] st = ST_OK);
    dir_row_t row;
    row.kind = kind;
    row.count = cnt;
    row.data = din;
    row.typed = typed;
    // typed rows all leave the full-size buffer empty
    row.res = '0;
    row.res.status = st;
    row.res.free_count = OUTW'(BRB_RESET_SIZE - 1);
    row.res.contig_write = OUTW'(BRB_RESET_SIZE - 1);
    return row;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DATAW-1:0] got,
                               input logic [DATAW-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [KINDW-1:0] kind, input logic [CNTW-1:0] cnt,
                              input logic [DATAW-1:0] din, input bit typed = 1'b0,
                              input ring_result_t typed_res = '0);
    int gap;
    ring_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= S_TDATA_W'({din, cnt});
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    r = ring_access(kind, int'(cnt), din);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic ring_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(input logic [SZW-1:0] v);
    int sz;
    ring_drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sz = int'(v);
    if (sz < BRB_MIN_SIZE) sz = BRB_MIN_SIZE;
    if (sz > BRB_DEPTH) sz = BRB_DEPTH;
    ring_size = sz;
    rd_ptr = 0;
    wr_ptr = 0;
    repeat (2) @(posedge clk);
  endtask

  task automatic gen_request(input int enq_w, output logic [KINDW-1:0] kind,
                             output logic [CNTW-1:0] cnt, output logic [DATAW-1:0] din);
    int r;
    int used;
    int run;
    int p;
    r = $urandom_range(0, enq_w + 49);
    din = {$urandom, $urandom};
    cnt = CNTW'($urandom_range(0, BRB_MAX_BYTES));
    if (r < enq_w) begin
      kind = KIND_ENQ;
    end else if (r < enq_w + 25) begin
      kind = KIND_DEQ;
    end else if (r < enq_w + 32) begin
      kind = KIND_PEEK;
    end else if (r < enq_w + 38) begin
      kind = KIND_SKIP;
      if ($urandom_range(0, 2) == 0) cnt = CNTW'($urandom_range(0, 1023));
    end else if (r < enq_w + 42) begin
      kind = KIND_ADV;
      if ($urandom_range(0, 3) == 0) cnt = CNTW'($urandom_range(0, 1023));
    end else if (r < enq_w + 44) begin
      kind = KIND_CLR;
      cnt = CNTW'($urandom_range(0, 1023));
    end else if (r < enq_w + 46) begin
      kind = $urandom_range(0, 1) ? KIND_RSVD_HI : KIND_RSVD_LO;
      cnt = CNTW'($urandom_range(0, 1023));
    end else begin
      kind = KIND_ENQ + KINDW'($urandom_range(0, 2));
      cnt = CNTW'($urandom_range(BRB_MAX_BYTES + 1, 1023));
    end
    // never read slots that hold no data yet
    used = ring_used();
    if ((kind == KIND_DEQ || kind == KIND_PEEK) && cnt <= BRB_MAX_BYTES && cnt <= used) begin
      run = 0;
      p = rd_ptr;
      for (int i = 0; i < cnt; i++) begin
        p = (p + 1) % ring_size;
        if (!slot_written[p]) break;
        run++;
      end
      cnt = CNTW'(run);
    end
  endtask

  task automatic run_phase(input logic [SZW-1:0] sz, input int n_items,
                           input int enq_w, input int hold);
    logic [KINDW-1:0] kind;
    logic [CNTW-1:0]  cnt;
    logic [DATAW-1:0] din;
    set_size(sz);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (hold > 0 && i == n_items / 3) rx_hold = hold;
      if (i == n_items / 2) ring_drain();
      gen_request(enq_w, kind, cnt, din);
      send_request(kind, cnt, din);
    end
  endtask

  // result side
  initial begin : rx_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OUT_BITS-1:0];
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", got.data_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", DATAW'(got.status), DATAW'(want.status));
        if (got.data_out !== want.data_out)
          flag_mismatch("data_out", got.data_out, want.data_out);
        if (got.used_count !== want.used_count)
          flag_mismatch("used_count", DATAW'(got.used_count), DATAW'(want.used_count));
        if (got.free_count !== want.free_count)
          flag_mismatch("free_count", DATAW'(got.free_count), DATAW'(want.free_count));
        if (got.contig_read !== want.contig_read)
          flag_mismatch("contig_read", DATAW'(got.contig_read),
                        DATAW'(want.contig_read));
        if (got.contig_write !== want.contig_write)
          flag_mismatch("contig_write", DATAW'(got.contig_write),
                        DATAW'(want.contig_write));
        if (got.read_position !== want.read_position)
          flag_mismatch("read_position", DATAW'(got.read_position),
                        DATAW'(want.read_position));
        if (got.write_position !== want.write_position)
          flag_mismatch("write_position", DATAW'(got.write_position),
                        DATAW'(want.write_position));
      end
    end
  end

  initial begin : stimulus
    dir_tab.push_back(make_row(KIND_DEQ, 10'd1, 64'd0, 1'b1, ST_NODATA));
    dir_tab.push_back(make_row(KIND_PEEK, 10'd0, 64'd0, 1'b1, ST_OK));
    dir_tab.push_back(make_row(KIND_ENQ, 10'd9, 64'h1122_3344_5566_7788, 1'b1, ST_BADCNT));
    dir_tab.push_back(make_row(KIND_RSVD_LO, 10'd0, 64'd0, 1'b1, ST_BADCNT));
    dir_tab.push_back(make_row(KIND_RSVD_HI, 10'd1023, '1, 1'b1, ST_BADCNT));
    dir_tab.push_back(make_row(KIND_ENQ, 10'd8, '1));
    dir_tab.push_back(make_row(KIND_ENQ, 10'd8, 64'h0123_4567_89ab_cdef));
    dir_tab.push_back(make_row(KIND_PEEK, 10'd8, 64'd0));
    dir_tab.push_back(make_row(KIND_DEQ, 10'd8, 64'd0));
    dir_tab.push_back(make_row(KIND_ENQ, 10'd0, 64'hdead_beef_cafe_f00d));
    dir_tab.push_back(make_row(KIND_SKIP, 10'd0, 64'd0));
    dir_tab.push_back(make_row(KIND_ADV, 10'd0, 64'd0));
    dir_tab.push_back(make_row(KIND_DEQ, 10'd9, 64'd0));
    dir_tab.push_back(make_row(KIND_PEEK, 10'd1023, 64'd0));
    dir_tab.push_back(make_row(KIND_SKIP, 10'd9, 64'd0));
    dir_tab.push_back(make_row(KIND_ADV, 10'd1008, 64'd0));
    dir_tab.push_back(make_row(KIND_ADV, 10'd8, 64'd0));
    dir_tab.push_back(make_row(KIND_ENQ, 10'd7, 64'h00a5_5a3c_c30f_f081));
    dir_tab.push_back(make_row(KIND_ENQ, 10'd1, 64'h0000_0000_0000_00ff));
    dir_tab.push_back(make_row(KIND_SKIP, 10'd1000, 64'd0));
    dir_tab.push_back(make_row(KIND_SKIP, 10'd16, 64'd0));
    dir_tab.push_back(make_row(KIND_DEQ, 10'd8, 64'd0));
    dir_tab.push_back(make_row(KIND_PEEK, 10'd7, 64'd0));
    dir_tab.push_back(make_row(KIND_DEQ, 10'd7, 64'd0));
    dir_tab.push_back(make_row(KIND_CLR, 10'd1023, '1, 1'b1, ST_OK));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (dir_tab[i])
      send_request(dir_tab[i].kind, dir_tab[i].count, dir_tab[i].data,
                   dir_tab[i].typed, dir_tab[i].res);

    run_phase(11'd1024, 200, 60, 300);
    run_phase(11'd2, 150, 40, 0);
    run_phase(11'd3, 150, 45, 0);
    run_phase(11'd9, 150, 45, 200);
    run_phase(11'd8, 150, 50, 0);
    run_phase(11'd100, 200, 50, 0);
    run_phase(11'd1023, 200, 55, 0);
    run_phase(11'd0, 100, 40, 0);
    run_phase(11'd2047, 200, 60, 0);
    run_phase(11'd1025, 100, 40, 0);
    run_phase(11'd17, 200, 45, 0);

    ring_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("byte_ring_buffer_top test passed");
    end else begin
      $display("byte_ring_buffer_top test failed");
    end
    $finish;
  end

endmodule
